[hdl/jse_pkg.sv]
// Shared types, codes and helpers for the JSON string escaper.
`default_nettype none
package jse_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_INVALID = 2'd1;
  localparam logic [1:0] ERR_RANGE   = 2'd2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [20:0] CP_MAX     = 21'h10ffff;
  localparam logic [20:0] CP_SUPP    = 21'h010000;
  localparam logic [5:0]  SURR_HI_TAG = 6'b110110;
  localparam logic [5:0]  SURR_LO_TAG = 6'b110111;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_ERROR
  } jse_mode_t;

  typedef enum logic [2:0] {
    CMD_CHAR,
    CMD_ESC2,
    CMD_U1,
    CMD_U2,
    CMD_ERR
  } jse_kind_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_value;
  } jse_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
    logic [1:0] error_code;
  } jse_out_t;

  // One command per input item that produces output.
  typedef struct packed {
    jse_kind_t   kind;
    logic [7:0]  ch;
    logic [1:0]  err;
    logic [15:0] w0;
    logic [15:0] w1;
  } jse_cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

  function automatic logic [3:0] cmd_len(input jse_kind_t kind);
    logic [3:0] n;
    case (kind)
      CMD_CHAR: n = 4'd1;
      CMD_ESC2: n = 4'd2;
      CMD_U1:   n = 4'd6;
      CMD_U2:   n = 4'd12;
      CMD_ERR:  n = 4'd1;
      default:  n = 4'd1;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

[hdl/jse_front.sv]
// Front end: accepts items, tracks string and UTF-8 decode state, issues commands.
`default_nettype none
module jse_front import jse_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    accept,
  input  wire jse_in_t in_data,
  output logic         push,
  output jse_cmd_t     push_cmd
);

  jse_mode_t   mode_r, mode_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [20:0] acc_shift;
  logic [20:0] supp;
  logic [7:0]  b;

  assign b         = in_data.byte_value;
  assign acc_shift = {acc_r[14:0], b[5:0]};
  assign supp      = acc_shift - CP_SUPP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pend_r <= 2'd0;
      acc_r  <= 21'd0;
    end else begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    push     = 1'b0;
    push_cmd = '{kind: CMD_CHAR, ch: CH_QUOTE, err: ERR_NONE, w0: 16'd0, w1: 16'd0};
    if (accept) begin
      case (in_data.action)
        ACT_START: begin
          mode_nxt = MODE_STRING;
          pend_nxt = 2'd0;
          acc_nxt  = 21'd0;
          push     = 1'b1;
        end
        ACT_END: begin
          if (mode_r == MODE_STRING) begin
            push = 1'b1;
            if (pend_r != 2'd0) begin
              push_cmd.kind = CMD_ERR;
              push_cmd.err  = ERR_INVALID;
              mode_nxt      = MODE_ERROR;
              pend_nxt      = 2'd0;
              acc_nxt       = 21'd0;
            end else begin
              mode_nxt = MODE_IDLE;
            end
          end
        end
        ACT_DATA: begin
          if (mode_r == MODE_STRING) begin
            if (pend_r == 2'd0) begin
              if (!b[7]) begin
                push        = 1'b1;
                push_cmd.ch = b;
                case (b)
                  CH_QUOTE, CH_BSLASH: push_cmd.kind = CMD_ESC2;
                  8'd8:  begin push_cmd.kind = CMD_ESC2; push_cmd.ch = 8'h62; end
                  8'd12: begin push_cmd.kind = CMD_ESC2; push_cmd.ch = 8'h66; end
                  8'd10: begin push_cmd.kind = CMD_ESC2; push_cmd.ch = 8'h6e; end
                  8'd13: begin push_cmd.kind = CMD_ESC2; push_cmd.ch = 8'h72; end
                  8'd9:  begin push_cmd.kind = CMD_ESC2; push_cmd.ch = 8'h74; end
                  default: begin
                    if (b < 8'd32 || b == 8'd127) begin
                      push_cmd.kind = CMD_U1;
                      push_cmd.w0   = {8'd0, b};
                    end else begin
                      push_cmd.kind = CMD_CHAR;
                    end
                  end
                endcase
              end else if (b[7:6] == 2'b10) begin
                push          = 1'b1;
                push_cmd.kind = CMD_ERR;
                push_cmd.err  = ERR_INVALID;
                mode_nxt      = MODE_ERROR;
                pend_nxt      = 2'd0;
                acc_nxt       = 21'd0;
              end else if (b[5:4] == 2'b11) begin
                pend_nxt = 2'd3;
                acc_nxt  = {18'd0, b[2:0]};
              end else if (b[5]) begin
                pend_nxt = 2'd2;
                acc_nxt  = {17'd0, b[3:0]};
              end else begin
                pend_nxt = 2'd1;
                acc_nxt  = {16'd0, b[4:0]};
              end
            end else if (b[7:6] != 2'b10) begin
              push          = 1'b1;
              push_cmd.kind = CMD_ERR;
              push_cmd.err  = ERR_INVALID;
              mode_nxt      = MODE_ERROR;
              pend_nxt      = 2'd0;
              acc_nxt       = 21'd0;
            end else if (pend_r != 2'd1) begin
              pend_nxt = pend_r - 2'd1;
              acc_nxt  = acc_shift;
            end else begin
              pend_nxt = 2'd0;
              acc_nxt  = 21'd0;
              push     = 1'b1;
              if (acc_shift > CP_MAX) begin
                push_cmd.kind = CMD_ERR;
                push_cmd.err  = ERR_RANGE;
                mode_nxt      = MODE_ERROR;
              end else if (acc_shift[20:16] == 5'd0) begin
                push_cmd.kind = CMD_U1;
                push_cmd.w0   = acc_shift[15:0];
              end else begin
                push_cmd.kind = CMD_U2;
                push_cmd.w0   = {SURR_HI_TAG, supp[19:10]};
                push_cmd.w1   = {SURR_LO_TAG, supp[9:0]};
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/jse_queue.sv]
// Short command queue between front end and output serializer.
`default_nettype none
module jse_queue import jse_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire jse_cmd_t push_cmd,
  input  wire logic     pop,
  output logic          full,
  output logic          head_valid,
  output jse_cmd_t      head_cmd
);

  jse_cmd_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (push && !do_pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not advance on push");

endmodule
`default_nettype wire

[hdl/jse_back.sv]
// Output serializer: expands queued commands into characters.
`default_nettype none
module jse_back import jse_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     head_valid,
  input  wire jse_cmd_t head_cmd,
  output logic          pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output jse_out_t      out_data
);

  logic [3:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  jse_out_t    out_data_r, out_data_nxt;
  logic        adv, load, last;
  logic        hi_half;
  logic [2:0]  sub;
  logic [15:0] word;
  logic [3:0]  nib;
  logic [7:0]  ch;

  assign adv     = !out_valid_r || out_ready;
  assign load    = adv && head_valid;
  assign last    = (idx_r == cmd_len(head_cmd.kind) - 4'd1);
  assign pop     = load && last;
  assign hi_half = (idx_r >= 4'd6);
  assign sub     = hi_half ? 3'(idx_r - 4'd6) : idx_r[2:0];
  assign word    = hi_half ? head_cmd.w1 : head_cmd.w0;

  always_comb begin
    case (sub)
      3'd2:    nib = word[15:12];
      3'd3:    nib = word[11:8];
      3'd4:    nib = word[7:4];
      default: nib = word[3:0];
    endcase
  end

  always_comb begin
    case (head_cmd.kind)
      CMD_CHAR: ch = head_cmd.ch;
      CMD_ESC2: ch = (idx_r == 4'd0) ? CH_BSLASH : head_cmd.ch;
      CMD_U1, CMD_U2: begin
        if (sub == 3'd0) begin
          ch = CH_BSLASH;
        end else if (sub == 3'd1) begin
          ch = CH_U;
        end else begin
          ch = hex_char(nib);
        end
      end
      CMD_ERR: ch = CH_NUL;
      default: ch = CH_NUL;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.out_char    = ch;
      out_data_nxt.last_of_run = last;
      out_data_nxt.error_code  = (head_cmd.kind == CMD_ERR) ? head_cmd.err : ERR_NONE;
      idx_nxt                  = last ? 4'd0 : idx_r + 4'd1;
    end else if (adv) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assert property (@(posedge clk) disable iff (!rst_n)
                   head_valid |-> idx_r < cmd_len(head_cmd.kind))
    else $error("serializer index past command length");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid_r && out_data_r.error_code != ERR_NONE) |->
                   (out_data_r.last_of_run && out_data_r.out_char == CH_NUL))
    else $error("error request not a lone null character");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (load && !last) |=> idx_r == $past(idx_r) + 4'd1)
    else $error("serializer index did not advance");

endmodule
`default_nettype wire

[hdl/json_string_escaper.sv]
// JSON string escaper: UTF-8 byte stream in, escaped ASCII characters out.
// Input channel in_valid/in_ready/in_data carries start, data byte and end
// requests; output channel out_valid/out_ready/out_data carries one character
// per transfer, with last_of_run marking the final one caused by an input item.
// An input item is taken when in_valid and in_ready are both high; with the
// queue empty its command is registered in the queue and its first character
// then in the output register. A plain ASCII byte gives one character, so such
// streams run at one item per cycle while out_ready stays high. Escapes give 2,
// \uXXXX 6 and a surrogate pair 12 characters, which the serializer emits
// one per cycle while out_ready is high; the front end stalls only when the
// four-entry queue is full. Lead bytes and ignored items produce no output.
// Reset (rst_n low, synchronous) empties the queue, clears the output
// valid flag and returns the decoder to idle outside any string.
// When out_ready is low the output character holds; the queue fills and
// in_ready drops once four commands are waiting.
`default_nettype none
module json_string_escaper import jse_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire jse_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output jse_out_t     out_data
);

  logic     accept;
  logic     push, pop, full, head_valid;
  jse_cmd_t push_cmd, head_cmd;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  jse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd)
  );

  jse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  jse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the JSON string escaper: directed and random requests.
`default_nettype none
module testbench;
  import jse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  ACT_NONE     = 2'd3;
  localparam logic [15:0] SURR_HI_BASE = 16'hd800;
  localparam logic [15:0] SURR_LO_BASE = 16'hdc00;
  localparam logic [7:0]  ESCAPE_BYTES [9] = '{8'h22, 8'h5c, 8'h08, 8'h0c, 8'h0a,
                                               8'h0d, 8'h09, 8'h7f, 8'h2f};

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  jse_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  jse_out_t out_data;

  json_string_escaper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // escaper state as predicted from accepted requests
  jse_mode_t   str_mode = MODE_IDLE;
  logic [1:0]  seq_left = '0;
  logic [20:0] cp_acc   = '0;
  jse_out_t    expected_chars[$];

  int          fail_count = 0;
  int unsigned sent_items = 0;
  bit          tx_idle    = 1'b1;
  bit          rx_idle    = 1'b1;
  int          hold_left  = 0;
  int          gap_left   = 0;

  function automatic void push_char(logic [7:0] ch, logic [1:0] code = ERR_NONE);
    jse_out_t r;
    r.out_char    = ch;
    r.last_of_run = 1'b0;
    r.error_code  = code;
    expected_chars.insert(expected_chars.size(), r);
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] nib);
    return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h61 + 8'(nib) - 8'd10;
  endfunction

  function automatic void push_u16(logic [15:0] v);
    push_char(CH_BSLASH);
    push_char(CH_U);
    for (int i = 3; i >= 0; i--) push_char(hex_digit(v[4*i +: 4]));
  endfunction

  function automatic void push_fault(logic [1:0] code);
    push_char(CH_NUL, code);
    str_mode = MODE_ERROR;
    seq_left = '0;
    cp_acc   = '0;
  endfunction

  function automatic void predict_escape(jse_in_t req);
    int          base;
    logic [7:0]  b;
    logic [7:0]  short_esc;
    logic [20:0] v;
    base = expected_chars.size();
    b    = req.byte_value;
    if (req.action == ACT_START) begin
      str_mode = MODE_STRING;
      seq_left = '0;
      cp_acc   = '0;
      push_char(CH_QUOTE);
    end else if (req.action == ACT_NONE || str_mode != MODE_STRING) begin
    end else if (req.action == ACT_END) begin
      if (seq_left != 0) begin
        push_fault(ERR_INVALID);
      end else begin
        push_char(CH_QUOTE);
        str_mode = MODE_IDLE;
      end
    end else if (seq_left == 0) begin
      if (b < 8'h80) begin
        short_esc = 8'h00;
        case (b)
          CH_QUOTE, CH_BSLASH: short_esc = b;
          8'h08: short_esc = "b";
          8'h0c: short_esc = "f";
          8'h0a: short_esc = "n";
          8'h0d: short_esc = "r";
          8'h09: short_esc = "t";
          default: ;
        endcase
        if (short_esc != 8'h00) begin
          push_char(CH_BSLASH);
          push_char(short_esc);
        end else if (b < 8'h20 || b == 8'h7f) begin
          push_u16({8'h00, b});
        end else begin
          push_char(b);
        end
      end else if (b >= 8'hf0) begin
        seq_left = 2'd3;
        cp_acc   = {18'd0, b[2:0]};
      end else if (b >= 8'he0) begin
        seq_left = 2'd2;
        cp_acc   = {17'd0, b[3:0]};
      end else if (b >= 8'hc0) begin
        seq_left = 2'd1;
        cp_acc   = {16'd0, b[4:0]};
      end else begin
        push_fault(ERR_INVALID);
      end
    end else if (b[7:6] != 2'b10) begin
      push_fault(ERR_INVALID);
    end else begin
      cp_acc   = {cp_acc[14:0], b[5:0]};
      seq_left = seq_left - 2'd1;
      if (seq_left == 0) begin
        if (cp_acc > CP_MAX) begin
          push_fault(ERR_RANGE);
        end else begin
          if (cp_acc < CP_SUPP) begin
            push_u16(cp_acc[15:0]);
          end else begin
            v = cp_acc - CP_SUPP;
            push_u16(SURR_HI_BASE + 16'(v[19:10]));
            push_u16(SURR_LO_BASE + 16'(v[9:0]));
          end
          cp_acc = '0;
        end
      end
    end
    if (expected_chars.size() > base) begin
      expected_chars[expected_chars.size() - 1].last_of_run = 1'b1;
    end
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      fail_count++;
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    jse_out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        gap_left = rx_idle ? $urandom_range(0, 9) : 0;
        if (expected_chars.size() == 0) begin
          fail_count++;
          $error("unexpected result: out_char %0h", out_data.out_char);
        end else begin
          want = expected_chars.pop_front();
          check_field("out_char", want.out_char, out_data.out_char);
          check_field("last_of_run", want.last_of_run, out_data.last_of_run);
          check_field("error_code", want.error_code, out_data.error_code);
        end
      end
      if (in_valid && in_ready) predict_escape(in_data);
    end
  end

  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_ready <= 1'b0;
        gap_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_request(logic [1:0] act, logic [7:0] value);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= jse_in_t'{action: act, byte_value: value};
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic send_string_char();
    int unsigned kind;
    int unsigned nbytes;
    logic [7:0]  lead;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: send_request(ACT_DATA, 8'($urandom_range(8'h20, 8'h7e)));
      4:          send_request(ACT_DATA, ESCAPE_BYTES[$urandom_range(0, 8)]);
      5:          send_request(ACT_DATA, 8'($urandom_range(0, 31)));
      9:          send_request(ACT_DATA, 8'($urandom_range(0, 127)));
      default: begin
        nbytes = kind - 4;
        case (nbytes)
          2:       lead = 8'hc0 | 8'($urandom_range(0, 31));
          3:       lead = 8'he0 | 8'($urandom_range(0, 15));
          default: lead = 8'($urandom_range(8'hf0, 8'hf4));
        endcase
        send_request(ACT_DATA, lead);
        repeat (nbytes - 1) send_request(ACT_DATA, 8'h80 | 8'($urandom_range(0, 63)));
      end
    endcase
  endtask

  task automatic test_directed_escapes();
    logic [7:0] chars [10] = '{8'h22, 8'h5c, 8'h08, 8'h0c, 8'h0a, 8'h0d, 8'h09,
                               8'h00, 8'h7f, 8'h7e};
    send_request(ACT_DATA, 8'h41);
    send_request(ACT_NONE, 8'hff);
    send_request(ACT_START, 8'h00);
    foreach (chars[i]) send_request(ACT_DATA, chars[i]);
  endtask

  task automatic test_directed_utf8();
    send_request(ACT_DATA, 8'hf0);
    send_request(ACT_DATA, 8'h9f);
    send_request(ACT_DATA, 8'h98);
    send_request(ACT_DATA, 8'h80);
    // restart with a sequence still open
    send_request(ACT_DATA, 8'he2);
    send_request(ACT_DATA, 8'h82);
    send_request(ACT_START, 8'hff);
  endtask

  task automatic test_directed_faults();
    send_request(ACT_DATA, 8'hc3);
    send_request(ACT_DATA, 8'h41);
    send_request(ACT_END, 8'h00);
    send_request(ACT_START, 8'h00);
    send_request(ACT_DATA, 8'h80);
    send_request(ACT_START, 8'h00);
    send_request(ACT_DATA, 8'hff);
    repeat (3) send_request(ACT_DATA, 8'hbf);
    send_request(ACT_START, 8'h00);
    send_request(ACT_DATA, 8'hc3);
    send_request(ACT_END, 8'h00);
  endtask

  task automatic test_random_strings(int unsigned n_items);
    int unsigned stop_at;
    int unsigned len;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      send_request(ACT_START, 8'($urandom));
      len = $urandom_range(0, 10);
      repeat (len) send_string_char();
      if ($urandom_range(0, 6) == 0) begin
        case ($urandom_range(0, 5))
          0: send_request(ACT_DATA, 8'($urandom_range(8'hc0, 8'hff)));
          1: send_request(ACT_DATA, 8'($urandom_range(8'h80, 8'hbf)));
          2: begin
            send_request(ACT_DATA, 8'($urandom_range(8'hc0, 8'hef)));
            send_request(ACT_DATA, $urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                                        : 8'($urandom_range(8'hc0, 8'hff)));
          end
          3: begin
            send_request(ACT_DATA, 8'($urandom_range(8'hf5, 8'hff)));
            repeat (3) send_request(ACT_DATA, 8'h80 | 8'($urandom_range(0, 63)));
          end
          4: send_request(ACT_NONE, 8'($urandom));
          default: send_request(ACT_DATA, 8'($urandom));
        endcase
        if ($urandom_range(0, 1)) send_request(ACT_DATA, 8'($urandom));
      end
      send_request(ACT_END, 8'($urandom));
      if ($urandom_range(0, 9) == 0) send_request(ACT_DATA, 8'($urandom));
    end
  endtask

  task automatic test_random_requests(int unsigned n_items);
    repeat (n_items) send_request(2'($urandom_range(0, 3)), 8'($urandom));
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    send_request(ACT_START, 8'h00);
    hold_left = 150;
    repeat (24) send_request(ACT_DATA, 8'($urandom_range(14, 31)));
    send_request(ACT_END, 8'h00);
    wait_drained();
    tx_idle = 1'b1;
  endtask

  task automatic test_no_idle();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random_strings(80);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_directed_escapes();
    test_directed_utf8();
    test_directed_faults();
    test_random_strings(150);
    test_backpressure();
    test_no_idle();
    test_random_requests(90);
    test_random_strings(150);
    wait_drained();
    repeat (24) @(posedge clk);
    if (fail_count == 0 && expected_chars.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("testbench failed");
    $finish;
  end

endmodule
`default_nettype wire
